// File: design/bucketed_recency_cache_macros.svh
// Assertion macros for the bucketed recency cache.
`ifndef BUCKETED_RECENCY_CACHE_MACROS_SVH
`define BUCKETED_RECENCY_CACHE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BRC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("brc assertion failed");

// next-cycle implication
`define BRC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("brc assertion failed");

`endif

// File: design/brc_pkg.sv
// Shared types and constants of the bucketed recency cache.
`default_nettype none
package brc_pkg;
	localparam int BUCKETS    = 4;
	localparam int SLOTS      = 8;
	localparam int BKT_W      = 2;
	localparam int SLOT_W     = 3;
	localparam int FILL_W     = 4;
	localparam int ADDR_W     = BKT_W + SLOT_W;
	localparam int KEY_W      = 32;
	localparam int LEN_W      = 16;
	localparam int DATA_W     = 64;
	localparam int TOT_W      = 33;
	localparam int CNT_W      = 6;
	localparam int RND_W      = 17;
	localparam int LFSR_W     = 16;
	localparam logic [RND_W-1:0]  MAX_ROUNDS = 17'd65536;
	localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;
	localparam logic [31:0] CAP_RESET  = 32'd65536;
	localparam logic [LFSR_W-1:0] SEED_RESET = 16'd1;
	localparam logic REG_CAP  = 1'b0;
	localparam logic REG_SEED = 1'b1;

	typedef struct packed {
		logic load;
		logic srch_rd;
		logic srch_cmp;
		logic promote;
		logic own_victim;
		logic ev_rd;
		logic ev_do;
		logic append;
		logic pick;
		logic finish;
	} brc_cmd_t;

	typedef struct packed {
		logic bkt_empty;
		logic match;
		logic last;
		logic found;
		logic op;
		logic len_nz;
		logic bkt_full;
		logic over;
		logic victim_nz;
		logic out_free;
	} brc_stat_t;
endpackage
`default_nettype wire

// File: design/brc_ctrl.sv
// Sequencer of the bucketed recency cache: search, promote, append, evict.
`default_nettype none
module brc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire brc_pkg::brc_stat_t st,
	output brc_pkg::brc_cmd_t       cmd
);
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SRD    = 4'd1;
	localparam logic [3:0] ST_SCMP   = 4'd2;
	localparam logic [3:0] ST_DECIDE = 4'd3;
	localparam logic [3:0] ST_EVRD   = 4'd4;
	localparam logic [3:0] ST_EVDO   = 4'd5;
	localparam logic [3:0] ST_APPEND = 4'd6;
	localparam logic [3:0] ST_LOOP   = 4'd7;
	localparam logic [3:0] ST_PCHK   = 4'd8;
	localparam logic [3:0] ST_DONE   = 4'd9;

	logic [3:0] state_q, state_d;
	logic       pend_q, pend_d;  // own-bucket eviction still owes the append

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		pend_d  = pend_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_SRD;
				end
			end
			ST_SRD: begin
				if (st.bkt_empty) begin
					state_d = ST_DECIDE;
				end else begin
					cmd.srch_rd = 1'b1;
					state_d     = ST_SCMP;
				end
			end
			ST_SCMP: begin
				cmd.srch_cmp = 1'b1;
				if (st.match || st.last) state_d = ST_DECIDE;
				else state_d = ST_SRD;
			end
			ST_DECIDE: begin
				if (!st.op || st.found) begin
					cmd.promote = st.op;
					state_d     = ST_DONE;
				end else if (!st.len_nz) begin
					state_d = ST_DONE;
				end else if (st.bkt_full) begin
					cmd.own_victim = 1'b1;
					pend_d         = 1'b1;
					state_d        = ST_EVRD;
				end else begin
					state_d = ST_APPEND;
				end
			end
			ST_EVRD: begin
				cmd.ev_rd = 1'b1;
				state_d   = ST_EVDO;
			end
			ST_EVDO: begin
				cmd.ev_do = 1'b1;
				pend_d    = 1'b0;
				state_d   = pend_q ? ST_APPEND : ST_LOOP;
			end
			ST_APPEND: begin
				cmd.append = 1'b1;
				state_d    = ST_LOOP;
			end
			ST_LOOP: begin
				if (st.over) begin
					cmd.pick = 1'b1;
					state_d  = ST_PCHK;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_PCHK: begin
				state_d = st.victim_nz ? ST_EVRD : ST_LOOP;
			end
			ST_DONE: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end
endmodule
`default_nettype wire

// File: design/brc_dp.sv
// Datapath: entry memory, per-bucket age order, totals, picker LFSR, result register.
`default_nettype none
module brc_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire brc_pkg::brc_cmd_t             cmd,
	output brc_pkg::brc_stat_t                 st,
	input  wire logic                          item_op,
	input  wire logic [brc_pkg::KEY_W-1:0]     item_key,
	input  wire logic [brc_pkg::LEN_W-1:0]     item_len,
	input  wire logic [brc_pkg::DATA_W-1:0]    item_data,
	input  wire logic [31:0]                   cap,
	input  wire logic                          seed_load,
	input  wire logic [brc_pkg::LFSR_W-1:0]    seed,
	output logic                               res_valid,
	input  wire logic                          res_taken,
	output logic [127:0]                       res_word
);
	localparam int EW = brc_pkg::DATA_W + brc_pkg::LEN_W + brc_pkg::KEY_W;

	logic [EW-1:0] mem [brc_pkg::BUCKETS*brc_pkg::SLOTS];
	logic [EW-1:0] rd_q;

	// physical slot of each age position; positions at or above fill are free
	logic [brc_pkg::SLOT_W-1:0] ord_q [brc_pkg::BUCKETS][brc_pkg::SLOTS];
	logic [brc_pkg::FILL_W-1:0] fill_q [brc_pkg::BUCKETS];
	logic [brc_pkg::TOT_W-1:0]  total_q;
	logic [brc_pkg::CNT_W-1:0]  held_q, ev_q;
	logic [brc_pkg::LFSR_W-1:0] lfsr_q, lfsr_nxt;
	logic [brc_pkg::RND_W-1:0]  rounds_q;
	logic [brc_pkg::BKT_W-1:0]  vic_q, pick_b, chosen;
	logic [brc_pkg::SLOT_W-1:0] idx_q, last_pos;
	logic                       found_q, op_q;
	logic [brc_pkg::KEY_W-1:0]  key_q;
	logic [brc_pkg::LEN_W-1:0]  len_q, rd_len, res_len;
	logic [brc_pkg::DATA_W-1:0] data_q, rd_data, res_data;
	logic [brc_pkg::KEY_W-1:0]  rd_key;
	logic [brc_pkg::BKT_W-1:0]  bkt;
	logic [brc_pkg::ADDR_W-1:0] ra, wa;
	logic                       res_ok, out_v_q;
	logic [127:0]               out_q;

	assign bkt     = key_q[brc_pkg::BKT_W-1:0];
	assign rd_key  = rd_q[brc_pkg::KEY_W-1:0];
	assign rd_len  = rd_q[brc_pkg::KEY_W +: brc_pkg::LEN_W];
	assign rd_data = rd_q[brc_pkg::KEY_W+brc_pkg::LEN_W +: brc_pkg::DATA_W];

	assign ra = cmd.ev_rd ? {vic_q, ord_q[vic_q][0]} : {bkt, ord_q[bkt][idx_q]};
	assign wa = {bkt, ord_q[bkt][fill_q[bkt][brc_pkg::SLOT_W-1:0]]};
	assign last_pos = fill_q[bkt][brc_pkg::SLOT_W-1:0] - 1'b1;

	assign lfsr_nxt = {1'b0, lfsr_q[brc_pkg::LFSR_W-1:1]}
		^ (lfsr_q[0] ? brc_pkg::LFSR_TAPS : '0);
	assign pick_b = lfsr_nxt[brc_pkg::BKT_W-1:0];
	// the written bucket only wins when strictly fuller
	assign chosen = (fill_q[bkt] > fill_q[pick_b]) ? bkt : pick_b;

	always_comb begin
		st.bkt_empty = (fill_q[bkt] == '0);
		st.match     = (rd_key == key_q);
		st.last      = ({1'b0, idx_q} + 1'b1) == fill_q[bkt];
		st.found     = found_q;
		st.op        = op_q;
		st.len_nz    = (len_q != '0);
		st.bkt_full  = (fill_q[bkt] == brc_pkg::FILL_W'(brc_pkg::SLOTS));
		st.over      = (total_q > {1'b0, cap}) && (held_q != '0)
			&& (rounds_q < brc_pkg::MAX_ROUNDS);
		st.victim_nz = (fill_q[vic_q] != '0);
		st.out_free  = !out_v_q || res_taken;
	end

	always_ff @(posedge clk) begin
		if (cmd.append) mem[wa] <= {data_q, len_q, key_q};
		if (cmd.srch_rd || cmd.ev_rd) rd_q <= mem[ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= item_op;
			key_q  <= item_key;
			len_q  <= item_len;
			data_q <= item_data;
		end
		if (cmd.finish) out_q <= {2'b0, ev_q, held_q, total_q, res_data, res_len, res_ok};
	end

	assign res_ok   = op_q ? (found_q || (len_q != '0)) : found_q;
	assign res_len  = (!op_q && found_q) ? rd_len : '0;
	assign res_data = (!op_q && found_q) ? rd_data : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < brc_pkg::BUCKETS; b++) begin
				fill_q[b] <= '0;
				for (int j = 0; j < brc_pkg::SLOTS; j++) ord_q[b][j] <= brc_pkg::SLOT_W'(j);
			end
			total_q  <= '0;
			held_q   <= '0;
			ev_q     <= '0;
			lfsr_q   <= brc_pkg::SEED_RESET;
			rounds_q <= '0;
			vic_q    <= '0;
			idx_q    <= '0;
			found_q  <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (seed_load) lfsr_q <= (seed == '0) ? brc_pkg::SEED_RESET : seed;
			if (cmd.load) begin
				idx_q    <= '0;
				found_q  <= 1'b0;
				ev_q     <= '0;
				rounds_q <= '0;
			end
			if (cmd.srch_cmp) begin
				if (st.match) found_q <= 1'b1;
				else idx_q <= idx_q + 1'b1;
			end
			if (cmd.promote) begin
				for (int j = 0; j < brc_pkg::SLOTS - 1; j++) begin
					if (brc_pkg::SLOT_W'(j) >= idx_q && brc_pkg::SLOT_W'(j) < last_pos)
						ord_q[bkt][j] <= ord_q[bkt][j+1];
				end
				ord_q[bkt][last_pos] <= ord_q[bkt][idx_q];
			end
			if (cmd.own_victim) vic_q <= bkt;
			if (cmd.pick) begin
				lfsr_q   <= lfsr_nxt;
				vic_q    <= chosen;
				rounds_q <= rounds_q + 1'b1;
			end
			if (cmd.ev_do) begin
				// oldest rotates to the free end
				for (int j = 0; j < brc_pkg::SLOTS - 1; j++) ord_q[vic_q][j] <= ord_q[vic_q][j+1];
				ord_q[vic_q][brc_pkg::SLOTS-1] <= ord_q[vic_q][0];
				fill_q[vic_q] <= fill_q[vic_q] - 1'b1;
				held_q  <= held_q - 1'b1;
				ev_q    <= ev_q + 1'b1;
				total_q <= total_q - {{(brc_pkg::TOT_W-brc_pkg::LEN_W){1'b0}}, rd_len};
			end
			if (cmd.append) begin
				fill_q[bkt] <= fill_q[bkt] + 1'b1;
				held_q  <= held_q + 1'b1;
				total_q <= total_q + {{(brc_pkg::TOT_W-brc_pkg::LEN_W){1'b0}}, len_q};
			end
			if (cmd.finish) out_v_q <= 1'b1;
			else if (res_taken) out_v_q <= 1'b0;
		end
	end

	assign res_valid = out_v_q;
	assign res_word  = out_q;
endmodule
`default_nettype wire

// File: design/bucketed_recency_cache.sv
// Top level of the bucketed recency cache: APB registers, sequencer and datapath.
//  channel   dir  handshake                 payload
//  s_*       in   s_tvalid/s_tready         s_tuser opcode, s_tdata key/length/data_word
//  m_*       out  m_tvalid/m_tready         m_tdata result fields
//  apb       in   psel/penable/pwrite       paddr, pwdata, prdata
// One request at a time. The key search reads one slot at a time, a read state and
// then a compare state per slot (single memory read port); an empty bucket skips the
// search. A new entry adds an append state, each eviction a read and a remove state
// and each round of the LFSR picker a pick and a check state. Results wait in an output
// register; the next request is taken once the previous result is loaded there.
// Reset is asynchronous and clears counts, bucket fills and age order; no sweep.
`default_nettype none
`include "bucketed_recency_cache_macros.svh"
module bucketed_recency_cache (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [111:0] s_tdata,   // key[31:0], length[47:32], data_word[111:48]
	input  wire logic         s_tuser,   // opcode
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [127:0]      m_tdata,   // ok[0], entry_length[16:1], entry_data[80:17],
	                                     // total_bytes[113:81], entry_count[119:114],
	                                     // evicted[125:120], zero fill
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	brc_pkg::brc_cmd_t  cmd;
	brc_pkg::brc_stat_t st;
	logic [31:0]                cap_q;
	logic [brc_pkg::LFSR_W-1:0] seed_q;
	logic                       cfg_wr, seed_load;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite;
	assign seed_load = cfg_wr && (paddr[2] == brc_pkg::REG_SEED);
	assign prdata    = (paddr[2] == brc_pkg::REG_CAP) ? cap_q : {16'b0, seed_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= brc_pkg::CAP_RESET;
			seed_q <= brc_pkg::SEED_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == brc_pkg::REG_CAP) cap_q <= pwdata;
			else seed_q <= pwdata[brc_pkg::LFSR_W-1:0];
		end
	end

	brc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	brc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.item_op   (s_tuser),
		.item_key  (s_tdata[31:0]),
		.item_len  (s_tdata[47:32]),
		.item_data (s_tdata[111:48]),
		.cap       (cap_q),
		.seed_load (seed_load),
		.seed      (pwdata[brc_pkg::LFSR_W-1:0]),
		.res_valid (m_tvalid),
		.res_taken (m_tready),
		.res_word  (m_tdata)
	);

	`BRC_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready)
	`BRC_ASSERT_NOW(a_count_bound, m_tvalid, m_tdata[119:114] <= 6'd32)
	`BRC_ASSERT_NOW(a_empty_no_bytes, m_tvalid && (m_tdata[119:114] == 6'd0), m_tdata[113:81] == 33'd0)
endmodule
`default_nettype wire
